[design/round_robin_thread_scheduler_macros.svh]
// Assertion macros for the round-robin thread scheduler.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH

// same-cycle implication, gated by reset
`define RRTS_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, gated by reset
`define RRTS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/rrts_pkg.sv]
// Shared types and codes for the round-robin thread scheduler.
// No dependencies.
package rrts_pkg;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_YIELD   = 3'd1,
        OP_SLEEP   = 3'd2,
        OP_JOIN    = 3'd3,
        OP_FINISH  = 3'd4,
        OP_KILL    = 3'd5,
        OP_CREATE  = 3'd6,
        OP_RELEASE = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        KIND_READY    = 3'd0,
        KIND_SLEEP    = 3'd1,
        KIND_JOIN     = 3'd2,
        KIND_FINISHED = 3'd3,
        KIND_EXITED   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_FOUND  = 3'd1,
        ST_DENIED     = 3'd2,
        ST_FULL       = 3'd3,
        ST_NOT_EXITED = 3'd4
    } status_t;

endpackage

[design/rrts_intf.sv]
// Request and response channel interfaces of the thread scheduler.
// No dependencies.
interface rrts_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic        preempt_blocked;
    logic [31:0] ticks;
    logic [3:0]  target_slot;
    logic [15:0] owner_uid;

    modport source (output valid, operation, preempt_blocked, ticks, target_slot,
                    owner_uid, input ready);
    modport sink (input valid, operation, preempt_blocked, ticks, target_slot,
                  owner_uid, output ready);
endinterface

interface rrts_rsp_if;
    logic       valid;
    logic       ready;
    logic [4:0] running_slot;
    logic       switched;
    logic       resume_code;
    logic [2:0] status;
    logic [3:0] new_slot;

    modport source (output valid, running_slot, switched, resume_code, status,
                    new_slot, input ready);
    modport sink (input valid, running_slot, switched, resume_code, status,
                  new_slot, output ready);
endinterface

[design/rrts_slot_ram.sv]
// Per-slot payload memory: sleep count, join target and owner uid.
// Synchronous, one read port, one write port with per-field enables.
module rrts_slot_ram #(
    parameter int SLOTS     = 16,
    parameter int TICK_BITS = 32
) (
    input  logic                     clk,
    input  logic [$clog2(SLOTS)-1:0] raddr,
    output logic [TICK_BITS-1:0]     rd_sleep,
    output logic [3:0]               rd_join,
    output logic [15:0]              rd_uid,
    input  logic [$clog2(SLOTS)-1:0] waddr,
    input  logic                     we_sleep,
    input  logic [TICK_BITS-1:0]     wr_sleep,
    input  logic                     we_join,
    input  logic [3:0]               wr_join,
    input  logic                     we_uid,
    input  logic [15:0]              wr_uid
);
    logic [TICK_BITS-1:0] sleep_mem [SLOTS];
    logic [3:0]           join_mem  [SLOTS];
    logic [15:0]          uid_mem   [SLOTS];

    always_ff @(posedge clk)
    begin
        if (we_sleep)
        begin
            sleep_mem[waddr] <= wr_sleep;
        end
        if (we_join)
        begin
            join_mem[waddr] <= wr_join;
        end
        if (we_uid)
        begin
            uid_mem[waddr] <= wr_uid;
        end
        rd_sleep <= sleep_mem[raddr];
        rd_join  <= join_mem[raddr];
        rd_uid   <= uid_mem[raddr];
    end
endmodule

[design/rrts_order_ram.sv]
// Round-robin order list memory, one slot number per position.
// Synchronous, one read port and one write port.
module rrts_order_ram #(
    parameter int SLOTS = 16
) (
    input  logic                     clk,
    input  logic [$clog2(SLOTS)-1:0] raddr,
    output logic [$clog2(SLOTS)-1:0] rdata,
    input  logic                     we,
    input  logic [$clog2(SLOTS)-1:0] waddr,
    input  logic [$clog2(SLOTS)-1:0] wdata
);
    logic [$clog2(SLOTS)-1:0] order_mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            order_mem[waddr] <= wdata;
        end
        rdata <= order_mem[raddr];
    end
endmodule

[design/round_robin_thread_scheduler.sv]
// Round-robin thread scheduler, top level. One request in flight: a new request is taken only
// once the previous one is in the response register. Create, release, blocked tick and failed
// checks answer directly; a kill of another slot reads both uids and checks permission; yield,
// sleep, join and finish search the order for the first ready slot and move the entries behind
// it forward, or fall back to idle with none ready; a tick first walks every order entry.
// Reset (async, rst_n low): all slots free, order empty, idle thread running.
module round_robin_thread_scheduler #(
    parameter int MAX_THREADS = 16,
    parameter int TICK_BITS   = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    rrts_req_if.sink   req,
    rrts_rsp_if.source rsp
);
    import rrts_pkg::*;

    `include "round_robin_thread_scheduler_macros.svh"

    localparam int SW = $clog2(MAX_THREADS);
    localparam int CW = $clog2(MAX_THREADS + 1);
    localparam logic [CW-1:0] IDLE_SLOT = CW'(MAX_THREADS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK_RD,
        S_WALK_SLOT,
        S_WALK_UPD,
        S_PICK_RD,
        S_PICK_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_KILL_RD_T,
        S_KILL_RD_C,
        S_KILL_CHK,
        S_DONE
    } state_t;

    // control and per-slot status flops
    state_t         state_reg,   state_next;
    logic [CW-1:0]  cur_reg,     cur_next;
    logic [CW-1:0]  before_reg,  before_next;
    logic [CW-1:0]  cnt_reg,     cnt_next;     // order length
    logic [CW-1:0]  idx_reg,     idx_next;     // read position in the order
    logic [CW-1:0]  wr_reg,      wr_next;      // compaction position during a walk
    status_t        status_reg,  status_next;
    logic [3:0]     created_reg, created_next;
    logic [SW-1:0]  slot_reg,    slot_next;    // slot under work
    logic [15:0]    uid_t_reg,   uid_t_next;
    logic [TICK_BITS-1:0] dt_reg, dt_next;
    logic [3:0]     tgt_reg,     tgt_next;
    logic [MAX_THREADS-1:0] valid_reg, valid_next;
    logic [MAX_THREADS-1:0] kill_reg,  kill_next;
    logic [MAX_THREADS-1:0] wake_reg,  wake_next;
    kind_t          kind_reg  [MAX_THREADS];
    kind_t          kind_next [MAX_THREADS];

    // response register
    logic           out_valid_reg, out_valid_next;
    logic [4:0]     out_run_reg,   out_run_next;
    logic           out_sw_reg,    out_sw_next;
    logic           out_wake_reg,  out_wake_next;
    logic [2:0]     out_st_reg,    out_st_next;
    logic [3:0]     out_new_reg,   out_new_next;

    // memory ports
    logic [SW-1:0]        sr_raddr, sr_waddr;
    logic [TICK_BITS-1:0] sr_rd_sleep, sr_wr_sleep;
    logic [3:0]           sr_rd_join, sr_wr_join;
    logic [15:0]          sr_rd_uid;
    logic                 sr_we_sleep, sr_we_join, sr_we_uid;
    logic [SW-1:0]        or_raddr, or_rdata, or_waddr, or_wdata;
    logic                 or_we;

    rrts_slot_ram #(.SLOTS(MAX_THREADS), .TICK_BITS(TICK_BITS)) u_slot_ram (
        .clk      (clk),
        .raddr    (sr_raddr),
        .rd_sleep (sr_rd_sleep),
        .rd_join  (sr_rd_join),
        .rd_uid   (sr_rd_uid),
        .waddr    (sr_waddr),
        .we_sleep (sr_we_sleep),
        .wr_sleep (sr_wr_sleep),
        .we_join  (sr_we_join),
        .wr_join  (sr_wr_join),
        .we_uid   (sr_we_uid),
        .wr_uid   (req.owner_uid)
    );

    rrts_order_ram #(.SLOTS(MAX_THREADS)) u_order_ram (
        .clk   (clk),
        .raddr (or_raddr),
        .rdata (or_rdata),
        .we    (or_we),
        .waddr (or_waddr),
        .wdata (or_wdata)
    );

    // lowest free slot for create
    logic          free_found;
    logic [SW-1:0] free_slot;
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = MAX_THREADS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_slot  = SW'(i);
            end
        end
    end

    // decodes of the running slot and of the request target
    logic          cur_live, tgt_live, tgt_is_cur;
    logic [SW-1:0] cur_idx, tgt_idx;
    assign cur_idx    = cur_reg[SW-1:0];
    assign cur_live   = (cur_reg != IDLE_SLOT) && valid_reg[cur_idx];
    assign tgt_idx    = SW'(req.target_slot);
    assign tgt_live   = (8'(req.target_slot) < 8'(MAX_THREADS)) && valid_reg[tgt_idx];
    assign tgt_is_cur = 8'(req.target_slot) == 8'(cur_reg);

    // walk decodes: join target of the slot under work
    logic          walk_tgt_live, walk_tgt_exited;
    logic [SW-1:0] walk_tgt_idx;
    assign walk_tgt_idx    = SW'(sr_rd_join);
    assign walk_tgt_live   = (8'(sr_rd_join) < 8'(MAX_THREADS)) && valid_reg[walk_tgt_idx];
    assign walk_tgt_exited = kind_reg[walk_tgt_idx] == KIND_EXITED;

    logic [15:0] my_uid;
    assign my_uid = cur_live ? sr_rd_uid : 16'd0;

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        before_next    = before_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        wr_next        = wr_reg;
        status_next    = status_reg;
        created_next   = created_reg;
        slot_next      = slot_reg;
        uid_t_next     = uid_t_reg;
        dt_next        = dt_reg;
        tgt_next       = tgt_reg;
        valid_next     = valid_reg;
        kill_next      = kill_reg;
        wake_next      = wake_reg;
        kind_next      = kind_reg;
        out_valid_next = out_valid_reg & ~rsp.ready;
        out_run_next   = out_run_reg;
        out_sw_next    = out_sw_reg;
        out_wake_next  = out_wake_reg;
        out_st_next    = out_st_reg;
        out_new_next   = out_new_reg;

        sr_raddr    = cur_idx;
        sr_waddr    = cur_idx;
        sr_we_sleep = 1'b0;
        sr_wr_sleep = TICK_BITS'(req.ticks);
        sr_we_join  = 1'b0;
        sr_wr_join  = req.target_slot;
        sr_we_uid   = 1'b0;
        or_raddr    = idx_reg[SW-1:0];
        or_we       = 1'b0;
        or_waddr    = idx_reg[SW-1:0];
        or_wdata    = slot_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    before_next  = cur_reg;
                    status_next  = ST_OK;
                    created_next = 4'd0;
                    dt_next      = TICK_BITS'(req.ticks);
                    tgt_next     = req.target_slot;
                    idx_next     = '0;
                    wr_next      = '0;
                    state_next   = S_PICK_RD;
                    unique case (op_t'(req.operation))
                        OP_TICK:
                        begin
                            state_next = req.preempt_blocked ? S_DONE : S_WALK_RD;
                        end
                        OP_YIELD:
                        begin
                            state_next = S_PICK_RD;
                        end
                        OP_SLEEP:
                        begin
                            if (cur_live)
                            begin
                                sr_we_sleep        = 1'b1;
                                kind_next[cur_idx] = KIND_SLEEP;
                            end
                        end
                        OP_JOIN:
                        begin
                            if (!tgt_live || tgt_is_cur)
                            begin
                                status_next = ST_NOT_FOUND;
                                state_next  = S_DONE;
                            end
                            else if (cur_live)
                            begin
                                sr_we_join         = 1'b1;
                                kind_next[cur_idx] = KIND_JOIN;
                            end
                        end
                        OP_FINISH:
                        begin
                            if (cur_live)
                            begin
                                kind_next[cur_idx] = KIND_FINISHED;
                            end
                        end
                        OP_KILL:
                        begin
                            if (tgt_is_cur)
                            begin
                                if (cur_live)
                                begin
                                    kind_next[cur_idx] = KIND_FINISHED;
                                end
                            end
                            else if (!tgt_live)
                            begin
                                status_next = ST_NOT_FOUND;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_KILL_RD_T;
                            end
                        end
                        OP_CREATE:
                        begin
                            state_next = S_DONE;
                            if (free_found)
                            begin
                                valid_next[free_slot] = 1'b1;
                                kind_next[free_slot]  = KIND_READY;
                                kill_next[free_slot]  = 1'b0;
                                wake_next[free_slot]  = 1'b0;
                                sr_we_uid             = 1'b1;
                                sr_waddr              = free_slot;
                                created_next          = 4'(free_slot);
                                if (cnt_reg < IDLE_SLOT)
                                begin
                                    or_we    = 1'b1;
                                    or_waddr = cnt_reg[SW-1:0];
                                    or_wdata = free_slot;
                                    cnt_next = cnt_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                status_next = ST_FULL;
                            end
                        end
                        OP_RELEASE:
                        begin
                            state_next = S_DONE;
                            if (!tgt_live)
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                            else if (kind_reg[tgt_idx] != KIND_EXITED)
                            begin
                                status_next = ST_NOT_EXITED;
                            end
                            else
                            begin
                                valid_next[tgt_idx] = 1'b0;
                                kind_next[tgt_idx]  = KIND_READY;
                                kill_next[tgt_idx]  = 1'b0;
                                wake_next[tgt_idx]  = 1'b0;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // tick walk: read order entry, then slot payload, then update
            S_WALK_RD:
            begin
                if (idx_reg >= cnt_reg)
                begin
                    cnt_next   = wr_reg;
                    idx_next   = '0;
                    state_next = S_PICK_RD;
                end
                else
                begin
                    state_next = S_WALK_SLOT;
                end
            end

            S_WALK_SLOT:
            begin
                sr_raddr   = or_rdata;
                slot_next  = or_rdata;
                state_next = S_WALK_UPD;
            end

            S_WALK_UPD:
            begin
                sr_waddr    = slot_reg;
                sr_wr_sleep = sr_rd_sleep - dt_reg;
                idx_next    = idx_reg + 1'b1;
                state_next  = S_WALK_RD;
                if (kind_reg[slot_reg] == KIND_FINISHED)
                begin
                    kind_next[slot_reg] = KIND_EXITED;
                end
                else
                begin
                    or_we    = 1'b1;
                    or_waddr = wr_reg[SW-1:0];
                    or_wdata = slot_reg;
                    wr_next  = wr_reg + 1'b1;
                    if (kind_reg[slot_reg] == KIND_READY || kind_reg[slot_reg] == KIND_EXITED)
                    begin
                        // nothing to do
                    end
                    else if (kill_reg[slot_reg])
                    begin
                        kind_next[slot_reg] = KIND_READY;
                        wake_next[slot_reg] = 1'b1;
                    end
                    else if (kind_reg[slot_reg] == KIND_SLEEP)
                    begin
                        if (sr_rd_sleep <= dt_reg)
                        begin
                            kind_next[slot_reg] = KIND_READY;
                            wake_next[slot_reg] = 1'b0;
                        end
                        else
                        begin
                            sr_we_sleep = 1'b1;
                        end
                    end
                    else if (kind_reg[slot_reg] == KIND_JOIN)
                    begin
                        if (!walk_tgt_live || walk_tgt_exited)
                        begin
                            kind_next[slot_reg] = KIND_READY;
                            wake_next[slot_reg] = 1'b0;
                        end
                    end
                end
            end

            // pick: first ready slot in the order, then rotate it to the back
            S_PICK_RD:
            begin
                if (idx_reg >= cnt_reg)
                begin
                    cur_next   = IDLE_SLOT;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_PICK_CHK;
                end
            end

            S_PICK_CHK:
            begin
                if (kind_reg[or_rdata] == KIND_READY)
                begin
                    slot_next  = or_rdata;
                    cur_next   = CW'(or_rdata);
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_PICK_RD;
                end
            end

            S_SHIFT_RD:
            begin
                if (idx_reg == cnt_reg - 1'b1)
                begin
                    or_we      = 1'b1;
                    or_wdata   = slot_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    or_raddr   = SW'(idx_reg + 1'b1);
                    state_next = S_SHIFT_WR;
                end
            end

            S_SHIFT_WR:
            begin
                or_we      = 1'b1;
                or_wdata   = or_rdata;
                idx_next   = idx_reg + 1'b1;
                state_next = S_SHIFT_RD;
            end

            // kill of another slot: fetch both uids, then check permission
            S_KILL_RD_T:
            begin
                sr_raddr   = SW'(tgt_reg);
                state_next = S_KILL_RD_C;
            end

            S_KILL_RD_C:
            begin
                uid_t_next = sr_rd_uid;
                state_next = S_KILL_CHK;
            end

            S_KILL_CHK:
            begin
                if (my_uid != 16'd0 && my_uid != uid_t_reg)
                begin
                    status_next = ST_DENIED;
                end
                else
                begin
                    kill_next[SW'(tgt_reg)] = 1'b1;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_run_next   = 5'(cur_reg);
                    out_sw_next    = cur_reg != before_reg;
                    out_wake_next  = cur_live & wake_reg[cur_idx];
                    out_st_next    = status_reg;
                    out_new_next   = created_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= IDLE_SLOT;
            cnt_reg       <= '0;
            valid_reg     <= '0;
            kill_reg      <= '0;
            wake_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_THREADS; i++)
            begin
                kind_reg[i] <= KIND_READY;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            cnt_reg       <= cnt_next;
            valid_reg     <= valid_next;
            kill_reg      <= kill_next;
            wake_reg      <= wake_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        before_reg  <= before_next;
        idx_reg     <= idx_next;
        wr_reg      <= wr_next;
        status_reg  <= status_next;
        created_reg <= created_next;
        slot_reg    <= slot_next;
        uid_t_reg   <= uid_t_next;
        dt_reg      <= dt_next;
        tgt_reg     <= tgt_next;
        out_run_reg <= out_run_next;
        out_sw_reg  <= out_sw_next;
        out_wake_reg <= out_wake_next;
        out_st_reg  <= out_st_next;
        out_new_reg <= out_new_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.running_slot = out_run_reg;
    assign rsp.switched     = out_sw_reg;
    assign rsp.resume_code  = out_wake_reg;
    assign rsp.status       = out_st_reg;
    assign rsp.new_slot     = out_new_reg;

    // between requests the running slot is a live, ready thread or idle
    `RRTS_ASSERT_NOW(a_cur_ready, (state_reg == S_IDLE && cur_reg != IDLE_SLOT), (valid_reg[cur_idx] && kind_reg[cur_idx] == KIND_READY), "running slot not live and ready")
    // the order never outgrows the slot table
    `RRTS_ASSERT_NOW(a_cnt_bound, 1'b1, (cnt_reg <= IDLE_SLOT), "order length beyond table size")
    // one request at a time
    `RRTS_ASSERT_NEXT(a_one_item, (req.valid && req.ready), (!req.ready), "request taken while busy")
endmodule
